// ===== src/tecpu_pkg.sv =====
// Shared types and constants for the tiny eight-register CPU core.
// Used by the sequencer, the register file and the top level; depends on nothing.
package tecpu_pkg;

  localparam logic [15:0] START_ADDRESS_RESET = 16'h7C00;
  localparam int unsigned REG_IDX_W = 3;

  // Opcodes
  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_MOV  = 8'h01;
  localparam logic [7:0] OP_MOVI = 8'h02;
  localparam logic [7:0] OP_LOAD = 8'h03;
  localparam logic [7:0] OP_JMP  = 8'h04;
  localparam logic [7:0] OP_ADD  = 8'h06;
  localparam logic [7:0] OP_HALT = 8'h07;

  // Status / stop codes
  localparam logic [1:0] STAT_RUN    = 2'd0;
  localparam logic [1:0] STAT_HALT   = 2'd1;
  localparam logic [1:0] STAT_BADREG = 2'd2;
  localparam logic [1:0] STAT_BADOP  = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_FETCH,
    ST_EXEC,
    ST_READB,
    ST_WRITEA,
    ST_LOAD,
    ST_EMIT,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [7:0]           value;
  } reg_wr_t;

  typedef struct packed {
    logic                 load;
    logic [1:0]           status;
    logic [REG_IDX_W-1:0] reg_index;
    logic [7:0]           reg_value;
    logic                 last;
  } res_t;

endpackage

// ===== src/tecpu_mem.sv =====
// Single-port byte memory with registered read data.
// Depends on nothing; addressed by the sequencer in tecpu_ctl.
module tecpu_mem #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata
);

  logic [7:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/tecpu_regfile.sv =====
// General register file: one read port, one write port, cleared at reset.
// Depends on tecpu_pkg for the write request type.
module tecpu_regfile #(
  parameter int unsigned REG_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [tecpu_pkg::REG_IDX_W-1:0]   rd_idx,
  output logic [7:0]                        rd_data,
  input  tecpu_pkg::reg_wr_t                wr
);
  import tecpu_pkg::*;

  localparam int unsigned RI_BITS = $clog2(REG_COUNT);

  logic [7:0] regs [REG_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= 8'd0;
      end
    end else if (wr.en) begin
      regs[wr.idx[RI_BITS-1:0]] <= wr.value;
    end
  end

  // Out-of-range indexes read as zero.
  assign rd_data = ({1'b0, rd_idx} < (REG_IDX_W+1)'(REG_COUNT)) ?
                   regs[rd_idx[RI_BITS-1:0]] : 8'd0;

endmodule

// ===== src/tecpu_ctl.sv =====
// Sequencer: memory clear sweep, instruction fetch, execute and result emission.
// Depends on tecpu_pkg; drives tecpu_mem and tecpu_regfile.
module tecpu_ctl #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned REG_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [15:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [15:0]                       address,
  input  logic [7:0]                        data,
  input  logic                              out_free,
  output tecpu_pkg::res_t                   res,
  output logic [15:0]                       pc_out,
  output logic                              mem_we,
  output logic [ADDR_BITS-1:0]              mem_addr,
  output logic [7:0]                        mem_wdata,
  input  logic [7:0]                        mem_rdata,
  output logic [tecpu_pkg::REG_IDX_W-1:0]   rd_idx,
  input  logic [7:0]                        rd_data,
  output tecpu_pkg::reg_wr_t                reg_wr
);
  import tecpu_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [ADDR_BITS-1:0] clr_cnt;
  logic [ADDR_BITS-1:0] pc;
  logic [1:0]           stop;
  logic [2:0]           fcnt;
  logic [REG_IDX_W-1:0] dcnt;
  logic [ADDR_BITS-1:0] addr_q;
  logic [7:0]           data_q;
  logic [7:0]           op;
  logic [7:0]           opa;
  logic [7:0]           opb;
  logic [7:0]           opc;
  logic [7:0]           tmp;

  logic [2:0]           pc_inc;
  logic [ADDR_BITS-1:0] pc_sum;
  logic                 a_bad;
  logic                 b_bad;
  logic                 dump_last;

  assign a_bad     = opa >= 8'(REG_COUNT);
  assign b_bad     = opb >= 8'(REG_COUNT);
  assign dump_last = dcnt == REG_IDX_W'(REG_COUNT - 1);

  // Shared program counter adder: fetch offsets and instruction lengths.
  assign pc_sum = pc + ADDR_BITS'(pc_inc);
  assign pc_out = 16'(pc);

  always_comb begin
    pc_inc = 3'd0;
    case (state)
      ST_FETCH: pc_inc = {1'b0, fcnt[1:0]};
      ST_EXEC: begin
        case (op)
          OP_NOP: pc_inc = 3'd1;
          OP_MOV, OP_ADD: pc_inc = a_bad ? 3'd1 : 3'd2;
          OP_MOVI: pc_inc = a_bad ? 3'd1 : 3'd3;
          OP_LOAD: pc_inc = 3'd1;
          default: pc_inc = 3'd0;
        endcase
      end
      ST_WRITEA: pc_inc = 3'd3;
      ST_LOAD:   pc_inc = 3'd4;
      default:   pc_inc = 3'd0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (&clr_cnt) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (!kind) begin
            state_next = ST_WRITE;
          end else if (stop != STAT_RUN) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_WRITE: state_next = ST_EMIT;
      ST_FETCH: if (fcnt == 3'd4) state_next = ST_EXEC;
      ST_EXEC: begin
        case (op)
          OP_MOV, OP_ADD: state_next = (a_bad || b_bad) ? ST_EMIT : ST_READB;
          OP_LOAD: state_next = a_bad ? ST_EMIT : ST_LOAD;
          OP_HALT: state_next = ST_DUMP;
          default: state_next = ST_EMIT;
        endcase
      end
      ST_READB:  state_next = ST_WRITEA;
      ST_WRITEA: state_next = ST_EMIT;
      ST_LOAD:   state_next = ST_EMIT;
      ST_EMIT:   if (out_free) state_next = ST_IDLE;
      ST_DUMP:   if (out_free && dump_last) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_addr  = pc_sum;
    mem_wdata = data_q;
    rd_idx    = opb[REG_IDX_W-1:0];
    reg_wr    = '0;
    res       = '0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = 8'd0;
      end
      ST_IDLE: in_stall = 1'b0;
      ST_WRITE: begin
        mem_we   = 1'b1;
        mem_addr = addr_q;
      end
      ST_EXEC: begin
        mem_addr = ADDR_BITS'({opb, opc});
        if (op == OP_MOVI && !a_bad) begin
          reg_wr.en    = 1'b1;
          reg_wr.idx   = opa[REG_IDX_W-1:0];
          reg_wr.value = opb;
        end
      end
      ST_READB: rd_idx = opb[REG_IDX_W-1:0];
      ST_WRITEA: begin
        rd_idx       = opa[REG_IDX_W-1:0];
        reg_wr.en    = 1'b1;
        reg_wr.idx   = opa[REG_IDX_W-1:0];
        reg_wr.value = (op == OP_ADD) ? rd_data + tmp : tmp;
      end
      ST_LOAD: begin
        reg_wr.en    = 1'b1;
        reg_wr.idx   = opa[REG_IDX_W-1:0];
        reg_wr.value = mem_rdata;
      end
      ST_EMIT: begin
        res.load   = out_free;
        res.status = stop;
        res.last   = 1'b1;
      end
      ST_DUMP: begin
        rd_idx        = dcnt;
        res.load      = out_free;
        res.status    = STAT_HALT;
        res.reg_index = dcnt;
        res.reg_value = rd_data;
        res.last      = dump_last;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      pc      <= START_ADDRESS_RESET[ADDR_BITS-1:0];
      stop    <= STAT_RUN;
      fcnt    <= 3'd0;
      dcnt    <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + ADDR_BITS'(1);
        ST_IDLE: begin
          addr_q <= address[ADDR_BITS-1:0];
          data_q <= data;
          fcnt   <= 3'd0;
        end
        ST_FETCH: begin
          fcnt <= fcnt + 3'd1;
          // Read data is registered and arrives in the cycle after its address.
          case (fcnt)
            3'd1:    op  <= mem_rdata;
            3'd2:    opa <= mem_rdata;
            3'd3:    opb <= mem_rdata;
            3'd4:    opc <= mem_rdata;
            default: op  <= op;
          endcase
        end
        ST_EXEC: begin
          dcnt <= '0;
          case (op)
            OP_NOP: pc <= pc_sum;
            OP_MOV, OP_ADD: begin
              if (a_bad || b_bad) begin
                pc   <= pc_sum;
                stop <= STAT_BADREG;
              end
            end
            OP_MOVI: begin
              pc <= pc_sum;
              if (a_bad) stop <= STAT_BADREG;
            end
            OP_LOAD: begin
              if (a_bad) begin
                pc   <= pc_sum;
                stop <= STAT_BADREG;
              end
            end
            OP_JMP:  pc   <= ADDR_BITS'({opa, opb});
            OP_HALT: stop <= STAT_HALT;
            default: stop <= STAT_BADOP;
          endcase
        end
        ST_READB:  tmp <= rd_data;
        ST_WRITEA: pc  <= pc_sum;
        ST_LOAD:   pc  <= pc_sum;
        ST_DUMP:   if (out_free) dcnt <= dcnt + REG_IDX_W'(1);
        default:   dcnt <= dcnt;
      endcase
      // Boot address write reloads the program counter.
      if (cfg_write) begin
        pc <= cfg_data[ADDR_BITS-1:0];
      end
    end
  end

endmodule

// ===== src/tiny_eight_register_cpu_core.sv =====
// Top level of the tiny eight-register CPU core: sequencer, memory,
// register file and the result output register. Depends on tecpu_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | kind, address, data
//   out     | out_valid / out_stall| status, pc, reg_index, reg_value, last
//   cfg     | cfg_write            | cfg_data (boot address)
//
// After reset the whole memory is swept to zero, one byte a cycle, with in_stall
// high. A write item passes through the write and emit states, a step on a
// stopped machine goes straight to emit. A running step fetches its instruction
// from the single-port memory, one byte per cycle; move and add then read and write a
// register, load reads memory, halt dumps registers. One item is in work at a time.
// A stalled result holds in the output register; the sequencer waits on it.
module tiny_eight_register_cpu_core #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned REG_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] pc,
  output logic [2:0]  reg_index,
  output logic [7:0]  reg_value,
  output logic        last
);
  import tecpu_pkg::*;

  res_t                 res;
  logic [15:0]          pc_cur;
  logic                 out_free;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           mem_wdata;
  logic [7:0]           mem_rdata;
  logic [REG_IDX_W-1:0] rd_idx;
  logic [7:0]           rd_data;
  reg_wr_t              reg_wr;

  assign out_free = !out_valid || !out_stall;

  tecpu_ctl #(
    .ADDR_BITS (ADDR_BITS),
    .REG_COUNT (REG_COUNT)
  ) u_ctl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .address   (address),
    .data      (data),
    .out_free  (out_free),
    .res       (res),
    .pc_out    (pc_cur),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .reg_wr    (reg_wr)
  );

  tecpu_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  tecpu_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr      (reg_wr)
  );

  // Output register: load a new item when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      status    <= res.status;
      pc        <= pc_cur;
      reg_index <= res.reg_index;
      reg_value <= res.reg_value;
      last      <= res.last;
    end
  end

`ifndef SYNTHESIS
  // An accepted item keeps the sequencer busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while sequencer still busy");

  // Only the halt dump shows a nonzero register number.
  a_index_only_in_dump: assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_index != 3'd0 |-> status == STAT_HALT)
    else $error("register index outside a halt dump");

  // A dump result that is taken and is not the final one is followed at once.
  a_dump_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("register dump broken off");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for tiny_eight_register_cpu_core: writes code bytes and
// steps the CPU, predicting every status and register dump item on the side.
// Depends on tecpu_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;
  import tecpu_pkg::*;

  localparam int REGS          = 8;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 300000;  // covers the memory sweep after reset
  localparam int RANDOM_ITEMS  = 75;

  typedef struct {
    logic        kind;
    logic [15:0] addr;
    logic [7:0]  dat;
  } bus_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] pc;
    logic [2:0]  reg_index;
    logic [7:0]  reg_value;
    logic        last;
  } cpu_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [15:0] address = '0;
  logic [7:0]  data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] pc;
  logic [2:0]  reg_index;
  logic [7:0]  reg_value;
  logic        last;

  // shadow machine
  logic [7:0]  mem_img [65536];
  logic [7:0]  gpr [REGS];
  logic [15:0] cpu_pc;
  logic [1:0]  cpu_stop;

  bus_item_t   bus_items[$];
  cpu_result_t results_due[$];
  logic [15:0] recent_addrs[$];
  logic [15:0] code_pc;
  int          items_made = 0;
  int          fail_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  tiny_eight_register_cpu_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .address   (address),
    .data      (data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .pc        (pc),
    .reg_index (reg_index),
    .reg_value (reg_value),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
    fail_count++;
  endtask

  task automatic expect_result(input logic [1:0] st, input logic [2:0] idx,
                               input logic [7:0] val, input logic lst);
    cpu_result_t r;
    r.status = st;
    r.pc = cpu_pc;
    r.reg_index = idx;
    r.reg_value = val;
    r.last = lst;
    results_due.push_back(r);
  endtask

  task automatic execute_item(input logic k, input logic [15:0] a, input logic [7:0] d);
    logic [15:0] p1, p2, p3, nxt_pc;
    logic [7:0]  op, b1, b2, b3;
    if (!k) begin
      mem_img[a] = d;
      expect_result(cpu_stop, 3'd0, 8'd0, 1'b1);
      return;
    end
    if (cpu_stop != STAT_RUN) begin
      expect_result(cpu_stop, 3'd0, 8'd0, 1'b1);
      return;
    end
    p1 = cpu_pc + 16'd1;
    p2 = cpu_pc + 16'd2;
    p3 = cpu_pc + 16'd3;
    op = mem_img[cpu_pc];
    b1 = mem_img[p1];
    b2 = mem_img[p2];
    b3 = mem_img[p3];
    nxt_pc = cpu_pc;
    case (op)
      OP_NOP: nxt_pc = p1;
      OP_MOV, OP_ADD: begin
        if (b1 >= REGS) begin
          nxt_pc = p1;
          cpu_stop = STAT_BADREG;
        end else if (b2 >= REGS) begin
          nxt_pc = p2;
          cpu_stop = STAT_BADREG;
        end else begin
          gpr[b1[2:0]] = (op == OP_MOV) ? gpr[b2[2:0]] : gpr[b1[2:0]] + gpr[b2[2:0]];
          nxt_pc = p3;
        end
      end
      OP_MOVI: begin
        if (b1 >= REGS) begin
          nxt_pc = p1;
          cpu_stop = STAT_BADREG;
        end else begin
          gpr[b1[2:0]] = b2;
          nxt_pc = p3;
        end
      end
      OP_LOAD: begin
        if (b1 >= REGS) begin
          nxt_pc = p1;
          cpu_stop = STAT_BADREG;
        end else begin
          gpr[b1[2:0]] = mem_img[{b2, b3}];
          nxt_pc = cpu_pc + 16'd4;
        end
      end
      OP_JMP: nxt_pc = {b1, b2};
      OP_HALT: cpu_stop = STAT_HALT;
      default: cpu_stop = STAT_BADOP;
    endcase
    cpu_pc = nxt_pc;
    if (op == OP_HALT) begin
      for (int i = 0; i < REGS; i++)
        expect_result(STAT_HALT, i[2:0], gpr[i], i == REGS - 1);
    end else begin
      expect_result(cpu_stop, 3'd0, 8'd0, 1'b1);
    end
  endtask

  task automatic send(input logic k, input logic [15:0] a, input logic [7:0] d);
    bus_item_t it;
    it.kind = k;
    it.addr = a;
    it.dat = d;
    bus_items.push_back(it);
    items_made++;
  endtask

  // address and data are don't-care on a step, so keep them random
  task automatic step_cpu();
    send(1'b1, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
  endtask

  task automatic noise_write();
    logic [15:0] a;
    a = 16'($urandom_range(16'hFFFF));
    send(1'b0, a, 8'($urandom_range(255)));
    recent_addrs.push_back(a);
    if (recent_addrs.size() > 8) void'(recent_addrs.pop_front());
  endtask

  // Store the instruction bytes at the next fetch address, then execute it.
  task automatic place_instr(input logic [7:0] op, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
    logic [7:0] code [4];
    int len;
    code[0] = op;
    code[1] = b1;
    code[2] = b2;
    code[3] = b3;
    case (op)
      OP_LOAD: len = 4;
      OP_MOV, OP_MOVI, OP_JMP, OP_ADD: len = 3;
      default: len = 1;
    endcase
    for (int i = 0; i < len; i++) send(1'b0, code_pc + i[15:0], code[i]);
    step_cpu();
    code_pc = (op == OP_JMP) ? {b1, b2} : code_pc + len[15:0];
  endtask

  task automatic random_code(input int count);
    int target, pick;
    logic [7:0] op, b1, b2, b3;
    logic [15:0] la;
    target = items_made + count;
    while (items_made < target) begin
      if ($urandom_range(3) == 0) noise_write();
      pick = $urandom_range(99);
      b1 = 8'($urandom_range(REGS - 1));
      b2 = 8'($urandom_range(REGS - 1));
      b3 = 8'($urandom_range(255));
      if (pick < 10) begin
        op = OP_NOP;
      end else if (pick < 28) begin
        op = OP_MOV;
      end else if (pick < 48) begin
        op = OP_MOVI;
        b2 = 8'($urandom_range(255));
      end else if (pick < 68) begin
        op = OP_LOAD;
        if (recent_addrs.size() != 0 && $urandom_range(1))
          la = recent_addrs[$urandom_range(recent_addrs.size() - 1)];
        else
          la = 16'($urandom_range(16'hFFFF));
        b2 = la[15:8];
        b3 = la[7:0];
      end else if (pick < 80) begin
        op = OP_JMP;
        case ($urandom_range(3))
          0: la = 16'hFFFE;
          1: la = 16'hFFFD;
          default: la = 16'($urandom_range(16'hFFFF));
        endcase
        b1 = la[15:8];
        b2 = la[7:0];
      end else begin
        op = OP_ADD;
      end
      place_instr(op, b1, b2, b3);
    end
  endtask

  // End the program: halt, a bad register operand or an unknown opcode.
  task automatic stop_machine();
    logic [7:0] first_ops [4];
    logic [7:0] bad;
    first_ops = '{OP_MOV, OP_MOVI, OP_LOAD, OP_ADD};
    bad = 8'($urandom_range(255, REGS));
    case ($urandom_range(5))
      0, 1, 2: place_instr(OP_HALT, 8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'd0);
      3: place_instr(first_ops[2'($urandom_range(3))], bad, 8'($urandom_range(REGS - 1)),
                     8'd0);
      4: place_instr($urandom_range(1) ? OP_MOV : OP_ADD, 8'($urandom_range(REGS - 1)),
                     bad, 8'd0);
      default: place_instr($urandom_range(1) ? 8'h05 : 8'($urandom_range(255, 8)),
                           8'd0, 8'd0, 8'd0);
    endcase
  endtask

  task automatic wait_idle();
    while (bus_items.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_boot(input logic [15:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    cpu_pc = v;
    code_pc = v;
    @(negedge clk);
  endtask

  // input side: hold a stalled item, otherwise offer the next one or idle
  always @(posedge clk) begin : drive_items
    bus_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) execute_item(kind, address, data);
      if (!in_valid || !in_stall) begin
        if (bus_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = bus_items.pop_front();
          in_valid <= 1'b1;
          kind <= nxt.kind;
          address <= nxt.addr;
          data <= nxt.dat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    cpu_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected item, pc", pc, 16'd0);
      end else begin
        want = results_due.pop_front();
        if (status !== want.status)
          report_mismatch("status", 16'(status), 16'(want.status));
        if (pc !== want.pc) report_mismatch("pc", pc, want.pc);
        if (reg_index !== want.reg_index)
          report_mismatch("reg_index", 16'(reg_index), 16'(want.reg_index));
        if (reg_value !== want.reg_value)
          report_mismatch("reg_value", 16'(reg_value), 16'(want.reg_value));
        if (last !== want.last) report_mismatch("last", 16'(last), 16'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (mem_img[i]) mem_img[i] = 8'd0;
    foreach (gpr[i]) gpr[i] = 8'd0;
    cpu_pc = START_ADDRESS_RESET;
    code_pc = START_ADDRESS_RESET;
    cpu_stop = STAT_RUN;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // memory sweep runs with the input stalled
    while (rst || in_stall !== 1'b0) @(negedge clk);

    tx_idle_pct = 26;
    rx_idle_pct = 70;
    place_instr(OP_NOP, 8'd0, 8'd0, 8'd0);
    wait_idle();

    // wrap the code across the top of memory
    set_boot(16'hFFFF);
    place_instr(OP_MOVI, 8'd0, 8'hFF, 8'd0);
    place_instr(OP_MOVI, 8'd7, 8'h01, 8'd0);
    place_instr(OP_ADD, 8'd0, 8'd7, 8'd0);
    place_instr(OP_LOAD, 8'd5, 8'hFF, 8'hFF);
    place_instr(OP_NOP, 8'd0, 8'd0, 8'd0);
    place_instr(OP_JMP, 8'h12, 8'h34, 8'd0);
    wait_idle();

    set_boot(16'h0000);
    random_code(RANDOM_ITEMS);
    wait_idle();

    tx_idle_pct = 70;
    rx_idle_pct = 26;
    set_boot(16'($urandom_range(16'hFFFF)));
    random_code(RANDOM_ITEMS);
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_boot(16'($urandom_range(16'hFFFF)));
    hold_req++;
    random_code(RANDOM_ITEMS);
    stop_machine();
    repeat (3) begin
      noise_write();
      step_cpu();
    end
    wait_idle();

    // a new boot address moves the pc but leaves the machine stopped
    set_boot(16'($urandom_range(16'hFFFF)));
    step_cpu();
    noise_write();
    step_cpu();
    wait_idle();

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
